// ----- rtl/ctfc_pkg.sv -----
package ctfc_pkg;

    localparam int OSC_W   = 27;
    localparam int DEN_W   = 9;
    localparam int FREQ_W  = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 192;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OSC_W-1:0] HSE_RESET = 27'd8000000;
    localparam logic [OSC_W-1:0] HSI_RESET = 27'd16000000;

    localparam logic REG_HSE = 1'b0;
    localparam logic REG_HSI = 1'b1;

    localparam logic [1:0] SWS_HSI   = 2'd0;
    localparam logic [1:0] SWS_HSE   = 2'd1;
    localparam logic [1:0] SWS_PLL_P = 2'd2;
    localparam logic [1:0] SWS_PLL_R = 2'd3;

    typedef struct packed {
        logic [OSC_W-1:0] src;
        logic [OSC_W-1:0] hsi;
        logic [OSC_W-1:0] hse;
        logic [DEN_W-1:0] den_p;
        logic [DEN_W-1:0] den_r;
        logic [8:0]       n;
        logic             m_zero;
        logic             r_zero;
        logic [1:0]       sws;
        logic [3:0]       ahb_sh;
        logic [2:0]       apb1_sh;
        logic [2:0]       apb2_sh;
        logic [2:0]       mco1_div;
        logic [2:0]       mco2_div;
        logic [4:0]       rtc;
    } ctfc_entry_t;

endpackage

// ----- rtl/ctfc_front.sv -----
module ctfc_front
    import ctfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [OSC_W-1:0]     cfg_data,
    input  logic [IN_W-1:0]      s_tdata,
    output ctfc_entry_t          entry
);

    logic [OSC_W-1:0] hse_reg;
    logic [OSC_W-1:0] hsi_reg;
    logic [31:0]      cfgr;
    logic [31:0]      pllc;
    logic [5:0]       m;
    logic [1:0]       pcode;
    logic [2:0]       pmul;
    logic [2:0]       r;
    logic [7:0]       mp;
    logic [3:0]       hpre;
    logic [2:0]       ppre1;
    logic [2:0]       ppre2;
    logic [2:0]       mco1;
    logic [2:0]       mco2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hse_reg <= HSE_RESET;
            hsi_reg <= HSI_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_HSE: hse_reg <= cfg_data;
                REG_HSI: hsi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfgr  = s_tdata[31:0];
        pllc  = s_tdata[63:32];
        m     = pllc[5:0];
        pcode = pllc[17:16];
        pmul  = {1'b0, pcode} + 3'd1;
        r     = pllc[30:28];
        mp    = {2'b00, m} * {5'b00000, pmul};
        hpre  = cfgr[7:4];
        ppre1 = cfgr[12:10];
        ppre2 = cfgr[15:13];
        mco1  = cfgr[26:24];
        mco2  = cfgr[29:27];

        entry.src    = pllc[22] ? hse_reg : hsi_reg;
        entry.hsi    = hsi_reg;
        entry.hse    = hse_reg;
        entry.den_p  = {mp, 1'b0};
        entry.den_r  = {3'b000, m} * {6'b000000, r};
        entry.n      = pllc[14:6];
        entry.m_zero = (m == 6'd0);
        entry.r_zero = (r == 3'd0);
        entry.sws    = cfgr[3:2];
        entry.ahb_sh = hpre[3] ? ({1'b0, hpre[2:0]} + 4'd1 + {3'b000, hpre[2]}) : 4'd0;
        entry.apb1_sh  = ppre1[2] ? ({1'b0, ppre1[1:0]} + 3'd1) : 3'd0;
        entry.apb2_sh  = ppre2[2] ? ({1'b0, ppre2[1:0]} + 3'd1) : 3'd0;
        entry.mco1_div = mco1[2] ? ({1'b0, mco1[1:0]} + 3'd2) : 3'd1;
        entry.mco2_div = mco2[2] ? ({1'b0, mco2[1:0]} + 3'd2) : 3'd1;
        entry.rtc    = cfgr[20:16];
    end

endmodule

// ----- rtl/ctfc_queue.sv -----
module ctfc_queue
    import ctfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ctfc_entry_t push_data,
    input  logic        pop,
    output ctfc_entry_t head,
    output logic        not_empty,
    output logic        not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctfc_entry_t      mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

    assign head      = mem[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != CNT_W'(DEPTH));

endmodule

// ----- rtl/ctfc_div.sv -----
module ctfc_div
    import ctfc_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [OSC_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [OSC_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [0:OSC_W];
    logic [OSC_W-1:0] q_reg   [0:OSC_W];
    logic [DEN_W-1:0] den_reg [0:OSC_W];

    always_comb
    begin
        rem_reg[0] = '0;
        q_reg[0]   = num;
        den_reg[0] = den;
    end

    for (genvar i = 0; i < OSC_W; i++)
    begin : g_stage
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[i], q_reg[i][OSC_W-1]};
            diff  = trial - {1'b0, den_reg[i]};
            ge    = (trial >= {1'b0, den_reg[i]});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                q_reg[i+1]   <= {q_reg[i][OSC_W-2:0], ge};
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quo = q_reg[OSC_W];

endmodule

// ----- rtl/ctfc_back.sv -----
module ctfc_back
    import ctfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ctfc_entry_t       in_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata
);

    localparam int LAST = OSC_W + 2;

    logic                vld_reg [1:LAST];
    ctfc_entry_t         side_reg [0:OSC_W+1];
    logic                en;
    logic [OSC_W-1:0]    q_p;
    logic [OSC_W-1:0]    q_r;
    logic [FREQ_W-1:0]   pll_prod_reg;
    logic [FREQ_W-1:0]   r_prod_reg;
    logic [FREQ_W-1:0]   pll;
    logic [FREQ_W-1:0]   sysr;
    logic [FREQ_W-1:0]   sys;
    logic [FREQ_W-1:0]   hclk;
    logic [OUT_W-1:0]    out_reg;
    ctfc_entry_t         e;

    assign en  = !vld_reg[LAST] || m_tready;
    assign pop = in_valid && en;

    ctfc_div u_div_p
    (
        .clk (clk),
        .en  (en),
        .num (in_entry.src),
        .den (in_entry.den_p),
        .quo (q_p)
    );

    ctfc_div u_div_r
    (
        .clk (clk),
        .en  (en),
        .num (in_entry.src),
        .den (in_entry.den_r),
        .quo (q_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= LAST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= LAST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign side_reg[0] = in_entry;

    for (genvar i = 0; i <= OSC_W; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_prod_reg <= FREQ_W'({{(FREQ_W-OSC_W){1'b0}}, q_p} *
                                    {{(FREQ_W-9){1'b0}}, side_reg[OSC_W].n});
            r_prod_reg   <= FREQ_W'({{(FREQ_W-OSC_W){1'b0}}, q_r} *
                                    {{(FREQ_W-9){1'b0}}, side_reg[OSC_W].n});
        end
    end

    always_comb
    begin
        e    = side_reg[OSC_W+1];
        pll  = e.m_zero ? '0 : pll_prod_reg;
        sysr = (e.m_zero || e.r_zero) ? '0 : r_prod_reg;
        case (e.sws)
            SWS_HSI:   sys = {{(FREQ_W-OSC_W){1'b0}}, e.hsi};
            SWS_HSE:   sys = {{(FREQ_W-OSC_W){1'b0}}, e.hse};
            SWS_PLL_P: sys = pll;
            default:   sys = sysr;
        endcase
        hclk = sys >> e.ahb_sh;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {e.m_zero || ((e.sws == SWS_PLL_R) && e.r_zero),
                        e.rtc,
                        e.mco2_div,
                        e.mco1_div,
                        5'd1 << e.apb2_sh,
                        5'd1 << e.apb1_sh,
                        10'd1 << e.ahb_sh,
                        hclk >> e.apb2_sh,
                        hclk >> e.apb1_sh,
                        hclk,
                        sys,
                        pll};
        end
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = out_reg;

endmodule

// ----- rtl/clock_tree_frequency_calc.sv -----
// clock tree frequency calculator: each transaction carries a snapshot of the clock
// configuration word and the pll configuration word and yields one result with the pll,
// system, ahb and apb frequencies plus the decoded prescalers. one transaction can be
// taken every cycle while the output is not stalled: the entry queue registers each
// transaction and hands it to the back end, which runs it through the 27-stage
// bit-per-cycle pipelined dividers of the pll p and r paths, one multiply stage and the
// output register, where the prescaler shifts are applied. oscillator registers must be
// written via cfg_we/cfg_addr/cfg_data only while idle; the block does not enforce it.
module clock_tree_frequency_calc
    import ctfc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [OSC_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    // cfgr_word, pllcfgr_word
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // pll_hz, sysclk_hz, hclk_hz, pclk1_hz, pclk2_hz, ahb_div, apb1_div, apb2_div,
    // mco1_div, mco2_div, rtc_prescale, divide_error
    output logic [OUT_W-1:0] m_tdata
);

    ctfc_entry_t front_entry;
    ctfc_entry_t head;
    logic        not_empty;
    logic        not_full;
    logic        pop;

    ctfc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .entry    (front_entry)
    );

    ctfc_queue #(.DEPTH(DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && not_full),
        .push_data (front_entry),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .not_full  (not_full)
    );

    ctfc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (not_empty),
        .in_entry (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    assign s_tready = not_full;

`ifndef SYNTH
    a_ahb_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot(m_tdata[169:160]))
        else $error("ahb divider not a power of two");

    a_apb_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($onehot(m_tdata[174:170]) && $onehot(m_tdata[179:175])))
        else $error("apb divider not a power of two");

    a_clk_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[95:64] <= m_tdata[63:32]) &&
                      (m_tdata[127:96] <= m_tdata[95:64]) &&
                      (m_tdata[159:128] <= m_tdata[95:64])))
        else $error("derived clock faster than its source");
`endif

endmodule

// ----- verif/clock_tree_frequency_calc_tb.sv -----
`timescale 1ns / 1ps

module clock_tree_frequency_calc_tb;
    import ctfc_pkg::*;

    typedef struct packed {
        logic [0:0]  divide_error;
        logic [4:0]  rtc_prescale;
        logic [2:0]  mco2_div;
        logic [2:0]  mco1_div;
        logic [4:0]  apb2_div;
        logic [4:0]  apb1_div;
        logic [9:0]  ahb_div;
        logic [31:0] pclk2_hz;
        logic [31:0] pclk1_hz;
        logic [31:0] hclk_hz;
        logic [31:0] sysclk_hz;
        logic [31:0] pll_hz;
    } freq_result_t;

    typedef struct {
        logic [31:0] cfgr;
        logic [31:0] pllc;
        bit          typed;
        freq_result_t want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_addr = 1'b0;
    logic [OSC_W-1:0] cfg_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    // cfgr_word, pllcfgr_word
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    // pll_hz, sysclk_hz, hclk_hz, pclk1_hz, pclk2_hz, ahb_div, apb1_div, apb2_div,
    // mco1_div, mco2_div, rtc_prescale, divide_error
    logic [OUT_W-1:0] m_tdata;

    logic [31:0] hse_hz = 32'd8000000;
    logic [31:0] hsi_hz = 32'd16000000;
    freq_result_t expected_freqs[$];
    int mismatches = 0;

    clock_tree_frequency_calc dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic freq_result_t calc_clock_tree(logic [31:0] cfgr, logic [31:0] pllc);
        freq_result_t r;
        logic [31:0] src, m, n, p, rd, pth;
        logic [3:0] hpre;
        logic [2:0] c;
        r = '0;
        hpre = cfgr[7:4];
        case (hpre[2:0])
            3'd0: r.ahb_div = 10'd2;
            3'd1: r.ahb_div = 10'd4;
            3'd2: r.ahb_div = 10'd8;
            3'd3: r.ahb_div = 10'd16;
            3'd4: r.ahb_div = 10'd64;
            3'd5: r.ahb_div = 10'd128;
            3'd6: r.ahb_div = 10'd256;
            default: r.ahb_div = 10'd512;
        endcase
        if (!hpre[3]) r.ahb_div = 10'd1;
        c = cfgr[12:10];
        r.apb1_div = c[2] ? (5'd2 << c[1:0]) : 5'd1;
        c = cfgr[15:13];
        r.apb2_div = c[2] ? (5'd2 << c[1:0]) : 5'd1;
        c = cfgr[26:24];
        r.mco1_div = c[2] ? (3'(c[1:0]) + 3'd2) : 3'd1;
        c = cfgr[29:27];
        r.mco2_div = c[2] ? (3'(c[1:0]) + 3'd2) : 3'd1;
        r.rtc_prescale = cfgr[20:16];
        m = 32'(pllc[5:0]);
        n = 32'(pllc[14:6]);
        p = (32'(pllc[17:16]) + 32'd1) * 32'd2;
        rd = 32'(pllc[30:28]);
        src = pllc[22] ? hse_hz : hsi_hz;
        if (m == 0)
        begin
            r.divide_error = 1'b1;
            r.pll_hz = 0;
        end
        else
            r.pll_hz = ((src / m) / p) * n;
        case (cfgr[3:2])
            SWS_HSI: r.sysclk_hz = hsi_hz;
            SWS_HSE: r.sysclk_hz = hse_hz;
            SWS_PLL_P: r.sysclk_hz = r.pll_hz;
            default:
            begin
                if (m == 0 || rd == 0)
                begin
                    r.divide_error = 1'b1;
                    r.sysclk_hz = 0;
                end
                else
                    r.sysclk_hz = ((src / m) / rd) * n;
            end
        endcase
        r.hclk_hz = r.sysclk_hz / 32'(r.ahb_div);
        r.pclk1_hz = r.hclk_hz / 32'(r.apb1_div);
        r.pclk2_hz = r.hclk_hz / 32'(r.apb2_div);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic write_osc(logic addr, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value[OSC_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_HSE) hse_hz = value & 32'h7FFFFFF;
        else hsi_hz = value & 32'h7FFFFFF;
    endtask

    task automatic send_item(logic [31:0] cfgr, logic [31:0] pllc, freq_result_t want);
        @(posedge clk);
        while ($urandom_range(0, 3) == 0) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {pllc, cfgr};
        expected_freqs.push_back(want);
        do @(posedge clk); while (!s_tready);
        if ($urandom_range(0, 2) != 0)
            s_tvalid <= 1'b0;
        else
            s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (expected_freqs.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // burst sender: holds tvalid across back-to-back transactions
    task automatic send_burst(int count);
        logic [31:0] c, p;
        for (int i = 0; i < count; i++)
        begin
            c = $urandom;
            p = $urandom;
            if ($urandom_range(0, 3) != 0)
            begin
                p[5:0] = 6'($urandom_range(1, 63));
                p[30:28] = 3'($urandom_range(1, 7));
            end
            s_tvalid <= 1'b1;
            s_tdata <= {p, c};
            expected_freqs.push_back(calc_clock_tree(c, p));
            do @(posedge clk); while (!s_tready);
        end
        s_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 15) < 11) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge clk)
    begin
        freq_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_freqs.size() == 0)
            begin
                report_mismatch("unexpected transaction", got.pll_hz, 32'd0);
            end
            else
            begin
                want = expected_freqs.pop_front();
                if (got.pll_hz != want.pll_hz) report_mismatch("pll_hz", got.pll_hz, want.pll_hz);
                if (got.sysclk_hz != want.sysclk_hz)
                    report_mismatch("sysclk_hz", got.sysclk_hz, want.sysclk_hz);
                if (got.hclk_hz != want.hclk_hz) report_mismatch("hclk_hz", got.hclk_hz, want.hclk_hz);
                if (got.pclk1_hz != want.pclk1_hz)
                    report_mismatch("pclk1_hz", got.pclk1_hz, want.pclk1_hz);
                if (got.pclk2_hz != want.pclk2_hz)
                    report_mismatch("pclk2_hz", got.pclk2_hz, want.pclk2_hz);
                if (got.ahb_div != want.ahb_div) report_mismatch("ahb_div", got.ahb_div, want.ahb_div);
                if (got.apb1_div != want.apb1_div)
                    report_mismatch("apb1_div", got.apb1_div, want.apb1_div);
                if (got.apb2_div != want.apb2_div)
                    report_mismatch("apb2_div", got.apb2_div, want.apb2_div);
                if (got.mco1_div != want.mco1_div)
                    report_mismatch("mco1_div", got.mco1_div, want.mco1_div);
                if (got.mco2_div != want.mco2_div)
                    report_mismatch("mco2_div", got.mco2_div, want.mco2_div);
                if (got.rtc_prescale != want.rtc_prescale)
                    report_mismatch("rtc_prescale", got.rtc_prescale, want.rtc_prescale);
                if (got.divide_error != want.divide_error)
                    report_mismatch("divide_error", got.divide_error, want.divide_error);
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        freq_result_t w;
        logic [31:0] osc_set[4];
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: hsi selected, all prescalers 1
        w = '0;
        w.sysclk_hz = 32'd16000000; w.hclk_hz = 32'd16000000;
        w.pclk1_hz = 32'd16000000; w.pclk2_hz = 32'd16000000;
        w.ahb_div = 10'd1; w.apb1_div = 5'd1; w.apb2_div = 5'd1;
        w.mco1_div = 3'd1; w.mco2_div = 3'd1; w.divide_error = 1'b1;
        rows.push_back('{32'h0, 32'h0, 1'b1, w});
        // hse selected, zero m
        w.sysclk_hz = 32'd8000000; w.hclk_hz = 32'd8000000;
        w.pclk1_hz = 32'd8000000; w.pclk2_hz = 32'd8000000;
        rows.push_back('{32'h4, 32'h0, 1'b1, w});
        // pll via p with zero m
        w = '0;
        w.ahb_div = 10'd1; w.apb1_div = 5'd1; w.apb2_div = 5'd1;
        w.mco1_div = 3'd1; w.mco2_div = 3'd1; w.divide_error = 1'b1;
        rows.push_back('{32'h8, 32'h0, 1'b1, w});
        // pll via r with zero m
        rows.push_back('{32'hC, 32'h0040_0000, 1'b1, w});
        // zero r on pll via r path
        rows.push_back('{32'hC, 32'h0040_5A08, 1'b0, w});
        // zero r on pll via p path is fine
        rows.push_back('{32'h8, 32'h0040_5A08, 1'b0, w});
        rows.push_back('{32'h8, 32'h2040_5A08, 1'b0, w});
        rows.push_back('{32'hC, 32'h2000_5A10, 1'b0, w});
        // all ones, and max n multiply
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, w});
        rows.push_back('{32'h8, 32'h0043_7FC1, 1'b0, w});
        rows.push_back('{32'hC, 32'h7043_7FC1, 1'b0, w});
        for (int i = 0; i < 8; i++)
            rows.push_back('{32'((8 + i) << 4) | (32'(i % 4) << 10) | (32'(7 - (i % 4)) << 13)
                | (32'(i) << 24) | (32'(7 - i) << 27) | 32'h4 | (32'(i) << 16),
                32'h1043_2000 | 32'(i + 1) | (32'(i % 4) << 16), 1'b0, w});

        foreach (rows[i])
        begin
            row = rows[i];
            send_item(row.cfgr, row.pllc,
                row.typed ? row.want : calc_clock_tree(row.cfgr, row.pllc));
        end
        drain();

        osc_set[0] = 32'd0;
        osc_set[1] = 32'd100000000;
        osc_set[2] = 32'hFFFF_FFFF;
        osc_set[3] = 32'd25000000;
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph < 4)
            begin
                write_osc(REG_HSE, osc_set[ph]);
                write_osc(REG_HSI, osc_set[3 - ph]);
            end
            else
            begin
                write_osc(REG_HSE, $urandom);
                write_osc(REG_HSI, $urandom_range(0, 100000000));
            end
            for (int sent = 0; sent < 120;)
            begin
                int b;
                b = $urandom_range(1, 20);
                send_burst(b);
                sent += b;
                if ($urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                else if ($urandom_range(0, 7) == 0)
                    while (expected_freqs.size() != 0) @(posedge clk);
                else
                    @(posedge clk);
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
